[hdl/size_class_block_allocator_defines.svh]
// Assertion macros used by the allocator top level.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define SCBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define SCBA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/scba_pkg.sv]
`default_nettype none

package scba_pkg;

    localparam int DEF_POOL_CHUNKS = 16;
    localparam int CHUNK_BYTES     = 16 * 1024;
    localparam int NUM_CLASSES     = 5;
    localparam int MAX_POOLED_SIZE = 256;

    localparam int MIN_BLOCK   = MAX_POOLED_SIZE >> (NUM_CLASSES - 1);
    localparam int MIN_SHIFT   = $clog2(MIN_BLOCK);
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);

    localparam int TYPE_W      = 2;
    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 18;
    localparam int STATUS_W    = 2;
    localparam int CLASS_W     = $clog2(NUM_CLASSES);
    localparam int NEXT_W      = $clog2(CHUNK_BYTES / MIN_BLOCK + 1);
    localparam int ADDR_SLOT_W = ADDR_W - MIN_SHIFT;

    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] block_addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   grant_addr;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctrl_cmd;

    function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
        logic [CLASS_W-1:0] cls;
        cls = '0;
        for (int c = 0; c < NUM_CLASSES - 1; c++) begin
            if (size > SIZE_W'(MIN_BLOCK << c)) begin
                cls = CLASS_W'(c + 1);
            end
        end
        return cls;
    endfunction

    function automatic logic [NEXT_W-1:0] blocks_per_chunk(input logic [CLASS_W-1:0] cls);
        logic [NEXT_W-1:0] n;
        n = NEXT_W'(CHUNK_BYTES >> (MIN_SHIFT + int'(cls)));
        return n;
    endfunction

endpackage

`default_nettype wire

[hdl/scba_ram.sv]
`default_nettype none

module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/scba_ctrl.sv]
`default_nettype none

module scba_ctrl import scba_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    output t_ctrl_cmd o_cmd,
    output logic      o_done
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EXEC);
        end
    end

    assign o_busy        = (r_state == S_EXEC);
    assign o_cmd.capture = i_start && (r_state == S_IDLE);
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_done        = r_done;

endmodule

`default_nettype wire

[hdl/scba_dpath.sv]
`default_nettype none

module scba_dpath import scba_pkg::*; #(
    parameter int POOL_CHUNKS = DEF_POOL_CHUNKS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctrl_cmd i_cmd,
    input  wire t_req      i_req,
    output t_rsp           o_rsp
);

    localparam int SLOT_COUNT  = POOL_CHUNKS * (CHUNK_BYTES / MIN_BLOCK);
    localparam int LINK_DEPTH  = (SLOT_COUNT < (1 << ADDR_SLOT_W)) ? SLOT_COUNT
                                                                    : (1 << ADDR_SLOT_W);
    localparam int SLOT_W      = $clog2(LINK_DEPTH);
    localparam int LINK_W      = SLOT_W + 1;
    localparam int CNT_W       = $clog2(POOL_CHUNKS + 1);
    localparam int CHUNK_IDX_W = (POOL_CHUNKS > 1) ? $clog2(POOL_CHUNKS) : 1;
    localparam int unsigned POOL_BYTES = POOL_CHUNKS * CHUNK_BYTES;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_link;

    t_link                  r_head        [NUM_CLASSES];
    t_link                  n_head        [NUM_CLASSES];
    logic                   r_carve_vld   [NUM_CLASSES];
    logic                   n_carve_vld   [NUM_CLASSES];
    logic [CHUNK_IDX_W-1:0] r_carve_chunk [NUM_CLASSES];
    logic [CHUNK_IDX_W-1:0] n_carve_chunk [NUM_CLASSES];
    logic [NEXT_W-1:0]      r_carve_next  [NUM_CLASSES];
    logic [NEXT_W-1:0]      n_carve_next  [NUM_CLASSES];
    logic [CNT_W-1:0]       r_chunks_used;
    logic [CNT_W-1:0]       n_chunks_used;
    t_req                   r_req;
    logic [CLASS_W-1:0]     r_cls;
    t_rsp                   r_rsp;
    t_rsp                   n_rsp;

    logic [CLASS_W-1:0] in_cls;
    logic [SLOT_W-1:0]  free_slot;
    logic               free_in_pool;
    logic               wr_en;
    logic [LINK_W-1:0]  rd_data;
    logic [ADDR_W-1:0]  carve_base;
    logic [ADDR_W-1:0]  carve_off;

    assign in_cls       = class_of(i_req.req_size);
    assign free_slot    = SLOT_W'(r_req.block_addr[ADDR_W-1:MIN_SHIFT]);
    assign free_in_pool = (32'(r_req.block_addr) < POOL_BYTES);
    assign carve_base   = ADDR_W'(r_carve_chunk[r_cls]) << CHUNK_SHIFT;
    assign carve_off    = ADDR_W'(r_carve_next[r_cls]) << (MIN_SHIFT + int'(r_cls));

    scba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (free_slot),
        .i_wr_data (r_head[r_cls]),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (r_head[in_cls].slot),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_head        = r_head;
        n_carve_vld   = r_carve_vld;
        n_carve_chunk = r_carve_chunk;
        n_carve_next  = r_carve_next;
        n_chunks_used = r_chunks_used;
        n_rsp.grant_addr = '0;
        n_rsp.status     = ST_OK;
        wr_en            = 1'b0;
        if (i_cmd.exec) begin
            case (r_req.req_type)
                REQ_CLEAR: begin
                    for (int c = 0; c < NUM_CLASSES; c++) begin
                        n_head[c].valid = 1'b0;
                        n_carve_vld[c]  = 1'b0;
                        n_carve_next[c] = '0;
                    end
                    n_chunks_used = '0;
                end
                REQ_FREE, REQ_ALLOC: begin
                    if (r_req.req_size == '0) begin
                        n_rsp.status = ST_NULL;
                    end else if (r_req.req_size > SIZE_W'(MAX_POOLED_SIZE)) begin
                        n_rsp.status = ST_OVERSIZE;
                    end else if (r_req.req_type == REQ_FREE) begin
                        if (free_in_pool) begin
                            wr_en               = 1'b1;
                            n_head[r_cls].valid = 1'b1;
                            n_head[r_cls].slot  = free_slot;
                        end
                    end else if (r_head[r_cls].valid) begin
                        n_rsp.grant_addr = ADDR_W'(r_head[r_cls].slot) << MIN_SHIFT;
                        n_head[r_cls]    = t_link'(rd_data);
                    end else if (r_carve_vld[r_cls] &&
                                 (r_carve_next[r_cls] < blocks_per_chunk(r_cls))) begin
                        n_rsp.grant_addr    = carve_base + carve_off;
                        n_carve_next[r_cls] = r_carve_next[r_cls] + 1'b1;
                    end else if (r_chunks_used < CNT_W'(POOL_CHUNKS)) begin
                        n_rsp.grant_addr     = ADDR_W'(r_chunks_used) << CHUNK_SHIFT;
                        n_carve_vld[r_cls]   = 1'b1;
                        n_carve_chunk[r_cls] = CHUNK_IDX_W'(r_chunks_used);
                        n_carve_next[r_cls]  = NEXT_W'(1);
                        n_chunks_used        = r_chunks_used + 1'b1;
                    end else begin
                        n_rsp.status = ST_EXHAUSTED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c].valid <= 1'b0;
                r_carve_vld[c]  <= 1'b0;
                r_carve_next[c] <= '0;
            end
            r_chunks_used <= '0;
        end else begin
            r_head        <= n_head;
            r_carve_vld   <= n_carve_vld;
            r_carve_chunk <= n_carve_chunk;
            r_carve_next  <= n_carve_next;
            r_chunks_used <= n_chunks_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            r_cls <= in_cls;
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

[hdl/size_class_block_allocator.sv]
// Size-class block allocator for a fixed pool of 16 KiB chunks.
// A request (allocate, free or clear) is taken when start is high and busy
// is low. Each request gives exactly one response on o_rsp, marked by a
// one-cycle o_done strobe; the receiver must take it in that cycle.
// The accepting edge enters the EXEC state, and o_done is registered from
// that state, so the response is taken at the edge that ends the o_done
// strobe. Busy is high for the one cycle of EXEC; a new request may be taken
// while o_done is high. EXEC exists for the free-list link memory: its registered
// read of the head link is issued as the request is taken, and the head and
// the link are written back in the following cycle.
// Allocate pops the class free list, else carves the next block of the
// class's current chunk, else claims a new chunk; when the pool is used up
// the status reports exhaustion. Free pushes an in-pool block onto its list.
// A synchronous reset empties every list and releases all chunks at once;
// no clearing pass is needed and a request may be given in the next cycle.
`default_nettype none

`include "size_class_block_allocator_defines.svh"

module size_class_block_allocator import scba_pkg::*; #(
    parameter int POOL_CHUNKS = DEF_POOL_CHUNKS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);

    t_ctrl_cmd cmd;
    logic      accept;

    assign accept = start && !busy;

    scba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    scba_dpath #(
        .POOL_CHUNKS (POOL_CHUNKS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    `SCBA_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, accept, busy && cmd.exec)
    `SCBA_ASSERT_NEXT(a_busy_then_done, i_clk, i_rst_n, busy, o_done && !busy)
    `SCBA_ASSERT_SAME(a_done_after_exec, i_clk, i_rst_n, o_done, $past(cmd.exec))

endmodule

`default_nettype wire
